/* src/hcp_pkg.sv */
package hcp_pkg;

  localparam int MODULUS = 26;

  localparam int LETTER_W = 5;
  localparam int RES_W    = (MODULUS > 1) ? $clog2(MODULUS) : 1;
  localparam int INV_N    = 1 << RES_W;

  // products, dot sums and the biased determinant all stay below 2 * MODULUS^2
  localparam int PROD_W   = $clog2(2 * MODULUS * MODULUS);
  localparam int RECIP_W  = 16;
  localparam int QMUL_W   = PROD_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((1 << RECIP_W) / MODULUS);
  localparam logic [PROD_W-1:0]  MOD_P    = PROD_W'(MODULUS);
  localparam logic [RES_W:0]     MOD_R    = (RES_W + 1)'(MODULUS);
  localparam logic [PROD_W-1:0]  DET_BIAS = PROD_W'(MODULUS * MODULUS);

  localparam logic [LETTER_W-1:0] PAD_LETTER = LETTER_W'(23);

  localparam logic [LETTER_W-1:0] KEY_TL_RST = LETTER_W'(7);
  localparam logic [LETTER_W-1:0] KEY_TR_RST = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] KEY_BL_RST = LETTER_W'(11);
  localparam logic [LETTER_W-1:0] KEY_BR_RST = LETTER_W'(11);

  typedef enum logic [1:0] {
    REG_KEY_TL = 2'd0,
    REG_KEY_TR = 2'd1,
    REG_KEY_BL = 2'd2,
    REG_KEY_BR = 2'd3
  } reg_index_t;

  typedef logic [31:0][RES_W-1:0]    red5_tbl_t;
  typedef logic [INV_N-1:0][RES_W-1:0] inv_tbl_t;
  typedef logic [INV_N-1:0]          inv_ok_t;

  function automatic red5_tbl_t build_red5();
    red5_tbl_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = RES_W'(i % MODULUS);
    end
    return t;
  endfunction

  function automatic inv_tbl_t build_inv();
    inv_tbl_t t;
    t = '0;
    for (int r = 0; r < INV_N; r++) begin
      for (int x = MODULUS - 1; x >= 1; x--) begin
        if (r < MODULUS && ((r * x) % MODULUS) == 1) begin
          t[r] = RES_W'(x);
        end
      end
    end
    return t;
  endfunction

  function automatic inv_ok_t build_inv_ok();
    inv_ok_t t;
    t = '0;
    for (int r = 0; r < INV_N; r++) begin
      for (int x = 1; x < MODULUS; x++) begin
        if (r < MODULUS && ((r * x) % MODULUS) == 1) begin
          t[r] = 1'b1;
        end
      end
    end
    return t;
  endfunction

  localparam red5_tbl_t RED5_TBL = build_red5();
  localparam inv_tbl_t  INV_TBL  = build_inv();
  localparam inv_ok_t   INV_OK   = build_inv_ok();

  // quotient estimate by reciprocal, low by at most one
  function automatic logic [PROD_W-1:0] red_quot(input logic [PROD_W-1:0] x);
    logic [QMUL_W-1:0] p;
    p = QMUL_W'(x) * QMUL_W'(RECIP);
    return p[QMUL_W-1:RECIP_W];
  endfunction

  function automatic logic [RES_W-1:0] red_fin(input logic [PROD_W-1:0] x,
                                               input logic [PROD_W-1:0] q);
    logic [PROD_W-1:0] qm;
    logic [PROD_W-1:0] r;
    qm = PROD_W'(q * MOD_P);
    r  = x - qm;
    if (r >= MOD_P) begin
      r = r - MOD_P;
    end
    return r[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] neg_m(input logic [RES_W-1:0] v);
    logic [RES_W:0] t;
    t = MOD_R - {1'b0, v};
    return (v == '0) ? '0 : t[RES_W-1:0];
  endfunction

  function automatic logic [PROD_W-1:0] mul_r(input logic [RES_W-1:0] x,
                                              input logic [RES_W-1:0] y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

endpackage

/* src/hill_cipher_pair.sv */
// Hill cipher 2x2 on letter pairs, modulo hcp_pkg::MODULUS.
// Pipeline: eleven register stages from input transaction to result.
// Throughput: one pair per cycle; a stalled stage holds and bubbles close up.
// Reset: synchronous, active high; clears all stage valids and loads the key
// registers with 7, 8, 11, 11.
module hill_cipher_pair (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [hcp_pkg::LETTER_W-1:0]  first_letter,
  input  logic [hcp_pkg::LETTER_W-1:0]  second_letter,
  input  logic                          second_missing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcp_pkg::LETTER_W-1:0]  first_out,
  output logic [hcp_pkg::LETTER_W-1:0]  second_out,
  output logic                          key_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [hcp_pkg::LETTER_W-1:0]  cfg_data
);

  localparam int RW = hcp_pkg::RES_W;
  localparam int PW = hcp_pkg::PROD_W;

  logic [hcp_pkg::LETTER_W-1:0] key_tl, key_tr, key_bl, key_br;

  logic [11:1] vld;
  logic [11:1] rdy;

  // stage 1: reduced key and letters
  logic          s1_mode;
  logic [RW-1:0] s1_p0, s1_p1, s1_a, s1_b, s1_c, s1_d;
  // stage 2: biased determinant
  logic          s2_mode;
  logic [RW-1:0] s2_p0, s2_p1, s2_a, s2_b, s2_c, s2_d;
  logic [PW-1:0] s2_v;
  // stage 3: quotient
  logic          s3_mode;
  logic [RW-1:0] s3_p0, s3_p1, s3_a, s3_b, s3_c, s3_d;
  logic [PW-1:0] s3_v, s3_q;
  // stage 4: determinant
  logic          s4_mode;
  logic [RW-1:0] s4_p0, s4_p1, s4_a, s4_b, s4_c, s4_d, s4_det;
  // stage 5: inverse
  logic          s5_mode, s5_err;
  logic [RW-1:0] s5_p0, s5_p1, s5_a, s5_b, s5_c, s5_d, s5_inv, s5_nb, s5_nc;
  // stage 6: inverse key products
  logic          s6_mode, s6_err;
  logic [RW-1:0] s6_p0, s6_p1, s6_a, s6_b, s6_c, s6_d;
  logic [PW-1:0] s6_x00, s6_x01, s6_x10, s6_x11;
  // stage 7: quotients
  logic          s7_mode, s7_err;
  logic [RW-1:0] s7_p0, s7_p1, s7_a, s7_b, s7_c, s7_d;
  logic [PW-1:0] s7_x00, s7_x01, s7_x10, s7_x11;
  logic [PW-1:0] s7_q00, s7_q01, s7_q10, s7_q11;
  // stage 8: inverse key
  logic          s8_mode, s8_err;
  logic [RW-1:0] s8_p0, s8_p1, s8_a, s8_b, s8_c, s8_d;
  logic [RW-1:0] s8_i00, s8_i01, s8_i10, s8_i11;
  // stage 9: dot sums
  logic          s9_err;
  logic [PW-1:0] s9_y0, s9_y1;
  // stage 10: quotients
  logic          s10_err;
  logic [PW-1:0] s10_y0, s10_y1, s10_q0, s10_q1;

  logic [RW-1:0] m00, m01, m10, m11;
  logic [RW-1:0] r0, r1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_tl <= hcp_pkg::KEY_TL_RST;
      key_tr <= hcp_pkg::KEY_TR_RST;
      key_bl <= hcp_pkg::KEY_BL_RST;
      key_br <= hcp_pkg::KEY_BR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (hcp_pkg::reg_index_t'(cfg_index))
        hcp_pkg::REG_KEY_TL: key_tl <= cfg_data;
        hcp_pkg::REG_KEY_TR: key_tr <= cfg_data;
        hcp_pkg::REG_KEY_BL: key_bl <= cfg_data;
        hcp_pkg::REG_KEY_BR: key_br <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[11] = !vld[11] || !out_stall;
    for (int k = 10; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[11];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 11; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_mode <= mode;
      s1_p0   <= hcp_pkg::RED5_TBL[first_letter];
      s1_p1   <= (!mode && second_missing) ? hcp_pkg::RED5_TBL[hcp_pkg::PAD_LETTER]
                                           : hcp_pkg::RED5_TBL[second_letter];
      s1_a    <= hcp_pkg::RED5_TBL[key_tl];
      s1_b    <= hcp_pkg::RED5_TBL[key_tr];
      s1_c    <= hcp_pkg::RED5_TBL[key_bl];
      s1_d    <= hcp_pkg::RED5_TBL[key_br];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_mode <= s1_mode;
      s2_p0   <= s1_p0;
      s2_p1   <= s1_p1;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_c    <= s1_c;
      s2_d    <= s1_d;
      s2_v    <= hcp_pkg::mul_r(s1_a, s1_d) + hcp_pkg::DET_BIAS
                 - hcp_pkg::mul_r(s1_b, s1_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_mode <= s2_mode;
      s3_p0   <= s2_p0;
      s3_p1   <= s2_p1;
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_c    <= s2_c;
      s3_d    <= s2_d;
      s3_v    <= s2_v;
      s3_q    <= hcp_pkg::red_quot(s2_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_mode <= s3_mode;
      s4_p0   <= s3_p0;
      s4_p1   <= s3_p1;
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_c    <= s3_c;
      s4_d    <= s3_d;
      s4_det  <= hcp_pkg::red_fin(s3_v, s3_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_mode <= s4_mode;
      s5_p0   <= s4_p0;
      s5_p1   <= s4_p1;
      s5_a    <= s4_a;
      s5_b    <= s4_b;
      s5_c    <= s4_c;
      s5_d    <= s4_d;
      s5_inv  <= hcp_pkg::INV_TBL[s4_det];
      s5_err  <= !hcp_pkg::INV_OK[s4_det];
      s5_nb   <= hcp_pkg::neg_m(s4_b);
      s5_nc   <= hcp_pkg::neg_m(s4_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_mode <= s5_mode;
      s6_err  <= s5_err;
      s6_p0   <= s5_p0;
      s6_p1   <= s5_p1;
      s6_a    <= s5_a;
      s6_b    <= s5_b;
      s6_c    <= s5_c;
      s6_d    <= s5_d;
      s6_x00  <= hcp_pkg::mul_r(s5_d, s5_inv);
      s6_x01  <= hcp_pkg::mul_r(s5_nb, s5_inv);
      s6_x10  <= hcp_pkg::mul_r(s5_nc, s5_inv);
      s6_x11  <= hcp_pkg::mul_r(s5_a, s5_inv);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_mode <= s6_mode;
      s7_err  <= s6_err;
      s7_p0   <= s6_p0;
      s7_p1   <= s6_p1;
      s7_a    <= s6_a;
      s7_b    <= s6_b;
      s7_c    <= s6_c;
      s7_d    <= s6_d;
      s7_x00  <= s6_x00;
      s7_x01  <= s6_x01;
      s7_x10  <= s6_x10;
      s7_x11  <= s6_x11;
      s7_q00  <= hcp_pkg::red_quot(s6_x00);
      s7_q01  <= hcp_pkg::red_quot(s6_x01);
      s7_q10  <= hcp_pkg::red_quot(s6_x10);
      s7_q11  <= hcp_pkg::red_quot(s6_x11);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_mode <= s7_mode;
      s8_err  <= s7_err;
      s8_p0   <= s7_p0;
      s8_p1   <= s7_p1;
      s8_a    <= s7_a;
      s8_b    <= s7_b;
      s8_c    <= s7_c;
      s8_d    <= s7_d;
      s8_i00  <= hcp_pkg::red_fin(s7_x00, s7_q00);
      s8_i01  <= hcp_pkg::red_fin(s7_x01, s7_q01);
      s8_i10  <= hcp_pkg::red_fin(s7_x10, s7_q10);
      s8_i11  <= hcp_pkg::red_fin(s7_x11, s7_q11);
    end
  end

  always_comb begin
    if (s8_mode) begin
      m00 = s8_i00;
      m01 = s8_i01;
      m10 = s8_i10;
      m11 = s8_i11;
    end else begin
      m00 = s8_a;
      m01 = s8_b;
      m10 = s8_c;
      m11 = s8_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_err <= s8_err;
      s9_y0  <= hcp_pkg::mul_r(m00, s8_p0) + hcp_pkg::mul_r(m01, s8_p1);
      s9_y1  <= hcp_pkg::mul_r(m10, s8_p0) + hcp_pkg::mul_r(m11, s8_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_err <= s9_err;
      s10_y0  <= s9_y0;
      s10_y1  <= s9_y1;
      s10_q0  <= hcp_pkg::red_quot(s9_y0);
      s10_q1  <= hcp_pkg::red_quot(s9_y1);
    end
  end

  assign r0 = hcp_pkg::red_fin(s10_y0, s10_q0);
  assign r1 = hcp_pkg::red_fin(s10_y1, s10_q1);

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      key_error  <= s10_err;
      first_out  <= s10_err ? '0 : hcp_pkg::LETTER_W'(r0);
      second_out <= s10_err ? '0 : hcp_pkg::LETTER_W'(r1);
    end
  end

endmodule
